### design/escp_pkg.sv
// ----------------------------------------------------------------------------
// escp_pkg : shared types and constants of the ESC/P command parser
// Byte codes, parser phases, queue entry and configuration-derived values.
// ----------------------------------------------------------------------------
package escp_pkg;

  // stream bytes
  localparam logic [7:0] BYTE_ESC  = 8'h1B;
  localparam logic [7:0] BYTE_CR   = 8'h0D;
  localparam logic [7:0] BYTE_LF   = 8'h0A;
  localparam logic [7:0] BYTE_FF   = 8'h0C;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_A      = 8'h41;
  localparam logic [7:0] CH_2      = 8'h32;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_J      = 8'h4A;
  localparam logic [7:0] CH_JL     = 8'h6A;
  localparam logic [7:0] CH_K      = 8'h4B;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_Y      = 8'h59;
  localparam logic [7:0] CH_Z      = 8'h5A;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] MODE_D60A = 8'd0;
  localparam logic [7:0] MODE_D60B = 8'd32;
  localparam logic [7:0] MODE_D180A = 8'd3;
  localparam logic [7:0] MODE_D180B = 8'd39;

  // event codes
  localparam logic [1:0] EV_GLYPH    = 2'd0;
  localparam logic [1:0] EV_COLUMN   = 2'd1;
  localparam logic [1:0] EV_PAGE_END = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_DPI    = 2'd0;
  localparam logic [1:0] CFG_PAGE_H = 2'd1;
  localparam logic [1:0] CFG_SKIP   = 2'd2;

  // graphics density codes
  localparam logic [1:0] DENS_60  = 2'd0;
  localparam logic [1:0] DENS_120 = 2'd1;
  localparam logic [1:0] DENS_180 = 2'd2;
  localparam logic [1:0] DENS_240 = 2'd3;

  // reset values
  localparam int          DpiRst       = 144;
  localparam logic [9:0]  DPI_RST      = 10'(DpiRst);
  localparam logic [15:0] PAGE_H_RST   = 16'd1584;
  localparam logic [15:0] HEAD_COL_RST = 16'(DpiRst / 2);
  localparam logic [15:0] PITCH_RST    = 16'(DpiRst / 6);

  // reciprocals, floor(x/d) = (x*k) >> 20 over the value ranges used here
  localparam logic [17:0] K6   = 18'd174763;
  localparam logic [17:0] K9   = 18'd116509;
  localparam logic [17:0] K27  = 18'd38837;
  localparam logic [17:0] K72  = 18'd14564;
  localparam logic [17:0] K60  = 18'd17477;
  localparam logic [17:0] K120 = 18'd8739;
  localparam logic [17:0] K180 = 18'd5826;
  localparam logic [17:0] K240 = 18'd4370;
  // column offsets, (x*k) >> 29 for 24-bit x
  localparam logic [25:0] K15_29 = 26'd35791395;
  localparam logic [25:0] K45_29 = 26'd11930465;

  localparam logic [17:0] RND216 = 18'd108;
  localparam logic [17:0] RND72  = 18'd36;

  typedef enum logic [3:0] {
    PH_TEXT, PH_ESC, PH_PITCH216, PH_PITCH72, PH_FEED_DOWN, PH_FEED_UP,
    PH_BIT_LO, PH_BIT_HI, PH_DATA, PH_STAR_MODE, PH_STAR_LO, PH_STAR_HI
  } phase_t;

  typedef enum logic [4:0] {
    CLS_OTHER, CLS_ESC, CLS_CR, CLS_LF, CLS_FF, CLS_AT, CLS_PITCH216,
    CLS_PITCH72, CLS_SP6, CLS_SP8, CLS_SP7, CLS_FEED_DN, CLS_FEED_UP,
    CLS_GFX60, CLS_GFX120, CLS_GFX240, CLS_STAR
  } byte_class_t;

  typedef struct packed {
    logic [7:0]  data;
    byte_class_t cls;
    logic        printable;
    logic [1:0]  star_dens;
    logic [10:0] f216;
    logic [11:0] p72;
  } q_entry_t;

  typedef struct packed {
    logic [9:0]       dpi;
    logic             skip;
    logic [8:0]       half;
    logic [7:0]       p6;
    logic [6:0]       p8;
    logic [6:0]       p7;
    logic [3:0]       vscale;
    logic [3:0]       gscale;
    logic [6:0]       gadv;
    logic [3:0][3:0]  step_w;
    logic [3:0]       dens_lt;
    logic signed [16:0] bottom;
  } cfg_derived_t;

  function automatic logic [13:0] div_recip(input logic [15:0] x, input logic [17:0] k);
    logic [33:0] p;
    p = 34'(x) * 34'(k);
    return p[33:20];
  endfunction

  function automatic logic [3:0] clamp_1_15(input logic [13:0] v);
    logic [3:0] r;
    if (v == 14'd0) r = 4'd1;
    else if (v > 14'd15) r = 4'd15;
    else r = v[3:0];
    return r;
  endfunction

endpackage

### design/escp_cfg.sv
// ----------------------------------------------------------------------------
// escp_cfg : configuration registers
// Holds the written registers and the scale factors derived from them.
// ----------------------------------------------------------------------------
module escp_cfg (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [15:0]           cfg_wdata,
  output logic [9:0]            dpi,
  output escp_pkg::cfg_derived_t drv
);

  logic [9:0]  dpi_r;
  logic [15:0] page_h_r;
  logic        skip_r;
  escp_pkg::cfg_derived_t drv_r, drv_nxt;

  logic [13:0] q6, q72, q7, q60, q120, q180, q240, gsc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dpi_r    <= escp_pkg::DPI_RST;
      page_h_r <= escp_pkg::PAGE_H_RST;
      skip_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        escp_pkg::CFG_DPI:    dpi_r    <= cfg_wdata[9:0];
        escp_pkg::CFG_PAGE_H: page_h_r <= cfg_wdata;
        escp_pkg::CFG_SKIP:   skip_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    q6   = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K6);
    q72  = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K72);
    q7   = escp_pkg::div_recip(16'(dpi_r) * 16'd7, escp_pkg::K72);
    q60  = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K60);
    q120 = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K120);
    q180 = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K180);
    q240 = escp_pkg::div_recip(16'(dpi_r), escp_pkg::K240);
    gsc  = (dpi_r >= 10'd144) ? q72 : 14'd1;

    drv_nxt.dpi        = dpi_r;
    drv_nxt.skip       = skip_r;
    drv_nxt.half       = dpi_r[9:1];
    drv_nxt.p6         = q6[7:0];
    drv_nxt.p8         = dpi_r[9:3];
    drv_nxt.p7         = q7[6:0];
    drv_nxt.vscale     = escp_pkg::clamp_1_15(q72);
    drv_nxt.gscale     = escp_pkg::clamp_1_15(gsc);
    drv_nxt.gadv       = 7'(7'(gsc[3:0]) * 7'd6);
    drv_nxt.step_w[0]  = escp_pkg::clamp_1_15(q60);
    drv_nxt.step_w[1]  = escp_pkg::clamp_1_15(q120);
    drv_nxt.step_w[2]  = escp_pkg::clamp_1_15(q180);
    drv_nxt.step_w[3]  = escp_pkg::clamp_1_15(q240);
    drv_nxt.dens_lt[0] = dpi_r < 10'd60;
    drv_nxt.dens_lt[1] = dpi_r < 10'd120;
    drv_nxt.dens_lt[2] = dpi_r < 10'd180;
    drv_nxt.dens_lt[3] = dpi_r < 10'd240;
    // bottom margin may go negative for short pages
    drv_nxt.bottom     = $signed({1'b0, page_h_r}) - $signed({8'b0, dpi_r[9:1]});
  end

  // derived values are registered from the written configuration registers
  always_ff @(posedge clk) begin
    drv_r <= drv_nxt;
  end

  assign dpi = dpi_r;
  assign drv = drv_r;

endmodule

### design/escp_front.sv
// ----------------------------------------------------------------------------
// escp_front : byte intake and classification
// Registers each byte with its class and pre-scales it for the spacing and
// feed commands, then pushes the result into the command queue.
// ----------------------------------------------------------------------------
module escp_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic [9:0]          dpi,
  input  logic                q_full,
  output logic                push,
  output escp_pkg::q_entry_t  push_entry
);

  logic                  a_v_r, a_v_nxt;
  logic [7:0]            a_byte_r;
  escp_pkg::byte_class_t a_cls_r, cls;
  logic                  a_pr_r;
  logic [1:0]            a_sd_r, sdens;
  logic [17:0]           a_prod_r;
  logic                  take;
  logic [17:0]           v216, v72;
  logic [13:0]           q216, q72;

  always_comb begin
    unique case (in_data_byte) inside
      escp_pkg::BYTE_ESC: cls = escp_pkg::CLS_ESC;
      escp_pkg::BYTE_CR:  cls = escp_pkg::CLS_CR;
      escp_pkg::BYTE_LF:  cls = escp_pkg::CLS_LF;
      escp_pkg::BYTE_FF:  cls = escp_pkg::CLS_FF;
      escp_pkg::CH_AT:    cls = escp_pkg::CLS_AT;
      escp_pkg::CH_3:     cls = escp_pkg::CLS_PITCH216;
      escp_pkg::CH_A:     cls = escp_pkg::CLS_PITCH72;
      escp_pkg::CH_2:     cls = escp_pkg::CLS_SP6;
      escp_pkg::CH_0:     cls = escp_pkg::CLS_SP8;
      escp_pkg::CH_1:     cls = escp_pkg::CLS_SP7;
      escp_pkg::CH_J:     cls = escp_pkg::CLS_FEED_DN;
      escp_pkg::CH_JL:    cls = escp_pkg::CLS_FEED_UP;
      escp_pkg::CH_K:     cls = escp_pkg::CLS_GFX60;
      escp_pkg::CH_L, escp_pkg::CH_Y: cls = escp_pkg::CLS_GFX120;
      escp_pkg::CH_Z:     cls = escp_pkg::CLS_GFX240;
      escp_pkg::CH_STAR:  cls = escp_pkg::CLS_STAR;
      default:            cls = escp_pkg::CLS_OTHER;
    endcase
    // density for the case the byte turns out to be an ESC * mode
    case (in_data_byte) inside
      escp_pkg::MODE_D60A, escp_pkg::MODE_D60B:   sdens = escp_pkg::DENS_60;
      escp_pkg::MODE_D180A, escp_pkg::MODE_D180B: sdens = escp_pkg::DENS_180;
      default:                                    sdens = escp_pkg::DENS_120;
    endcase
  end

  assign in_stall = a_v_r && q_full;
  assign take     = in_valid && !in_stall;
  assign push     = a_v_r && !q_full;

  always_comb begin
    a_v_nxt = a_v_r;
    if (take) a_v_nxt = 1'b1;
    else if (push) a_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_byte_r <= in_data_byte;
      a_cls_r  <= cls;
      a_pr_r   <= (in_data_byte >= escp_pkg::CH_SPACE) && (in_data_byte <= escp_pkg::CH_TILDE);
      a_sd_r   <= sdens;
      a_prod_r <= 18'(in_data_byte) * 18'(dpi);
    end
  end

  // n*dpi/216 and n*dpi/72 with rounding, as shift then reciprocal
  always_comb begin
    v216 = a_prod_r + escp_pkg::RND216;
    v72  = a_prod_r + escp_pkg::RND72;
    q216 = escp_pkg::div_recip(16'(v216[17:3]), escp_pkg::K27);
    q72  = escp_pkg::div_recip(16'(v72[17:3]), escp_pkg::K9);
    push_entry.data      = a_byte_r;
    push_entry.cls       = a_cls_r;
    push_entry.printable = a_pr_r;
    push_entry.star_dens = a_sd_r;
    push_entry.f216      = q216[10:0];
    push_entry.p72       = q72[11:0];
  end

endmodule

### design/escp_queue.sv
// ----------------------------------------------------------------------------
// escp_queue : two-entry command queue
// Decouples the intake from the command execution.
// ----------------------------------------------------------------------------
module escp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  escp_pkg::q_entry_t push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output escp_pkg::q_entry_t head
);

  escp_pkg::q_entry_t ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent_r[wp_r] <= push_entry;
  end

  assign full      = cnt_r == 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head      = ent_r[rp_r];

endmodule

### design/escp_back.sv
// ----------------------------------------------------------------------------
// escp_back : command execution
// Parser state machine, head position, line pitch and graphics counters,
// with the result register.
// ----------------------------------------------------------------------------
module escp_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  escp_pkg::cfg_derived_t drv,
  input  logic                   q_valid,
  input  escp_pkg::q_entry_t     q_head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [1:0]             out_event_kind,
  output logic [15:0]            out_pos_x,
  output logic [15:0]            out_pos_y,
  output logic [7:0]             out_glyph_or_bits,
  output logic [3:0]             out_dot_width,
  output logic [3:0]             out_dot_height
);

  escp_pkg::phase_t phase_r, phase_nxt;
  logic        flp_r, flp_nxt;
  logic [1:0]  dens_r, dens_nxt;
  logic [7:0]  cnt_lo_r, cnt_lo_nxt;
  logic [1:0]  sdens_r, sdens_nxt;
  logic [15:0] exp_r, exp_nxt;
  logic [15:0] done_r, done_nxt;
  logic [15:0] col_r, col_nxt;
  logic [15:0] row_r, row_nxt;
  logic [15:0] pitch_r, pitch_nxt;
  logic [25:0] prod_r, prod_nxt;
  logic        out_v_r, out_v_nxt;

  logic        emit;
  logic [1:0]  ev_kind;
  logic [15:0] ev_x, ev_y;
  logic [7:0]  ev_g;
  logic [3:0]  ev_w, ev_h;

  logic [7:0]  b;
  logic [15:0] half16, f216_16, row_lf, done_inc, exp_val;
  logic [20:0] off_cur, off_end;
  logic [25:0] prod_next_col;
  logic        lt;

  function automatic logic [20:0] col_off(input logic [25:0] p, input logic [15:0] n,
                                          input logic [1:0] dens, input logic below);
    logic [23:0] x;
    logic [25:0] k;
    logic [49:0] m;
    case (dens)
      escp_pkg::DENS_60:  begin x = p[25:2];         k = escp_pkg::K15_29; end
      escp_pkg::DENS_120: begin x = {1'b0, p[25:3]}; k = escp_pkg::K15_29; end
      escp_pkg::DENS_180: begin x = p[25:2];         k = escp_pkg::K45_29; end
      default:            begin x = {2'b0, p[25:4]}; k = escp_pkg::K15_29; end
    endcase
    m = 50'(x) * 50'(k);
    return below ? 21'(n) : m[49:29];
  endfunction

  function automatic logic [15:0] sat16(input logic [21:0] v);
    return (v > 22'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  assign pop = q_valid && (!out_v_r || !out_stall);

  always_comb begin
    b             = q_head.data;
    half16        = 16'(drv.half);
    f216_16       = 16'(q_head.f216);
    row_lf        = sat16(22'(row_r) + 22'(pitch_r));
    done_inc      = done_r + 16'd1;
    lt            = drv.dens_lt[dens_r];
    prod_next_col = prod_r + 26'(drv.dpi);
    off_cur       = col_off(prod_r, done_r, dens_r, lt);
    off_end       = col_off(prod_next_col, exp_r, dens_r, lt);
    exp_val       = (phase_r == escp_pkg::PH_BIT_HI) ? {5'b0, b[2:0], cnt_lo_r}
                                                     : {b, cnt_lo_r};

    phase_nxt  = phase_r;
    flp_nxt    = flp_r;
    dens_nxt   = dens_r;
    cnt_lo_nxt = cnt_lo_r;
    sdens_nxt  = sdens_r;
    exp_nxt    = exp_r;
    done_nxt   = done_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    pitch_nxt  = pitch_r;
    // keep the product current while no column is taken
    prod_nxt   = 26'(done_r) * 26'(drv.dpi);

    emit    = 1'b0;
    ev_kind = escp_pkg::EV_GLYPH;
    ev_x    = 16'd0;
    ev_y    = 16'd0;
    ev_g    = 8'd0;
    ev_w    = 4'd0;
    ev_h    = 4'd0;

    if (pop) begin
      unique case (phase_r)
        escp_pkg::PH_ESC: begin
          phase_nxt = escp_pkg::PH_TEXT;
          unique case (q_head.cls)
            escp_pkg::CLS_AT: begin
              pitch_nxt = 16'(drv.p6);
              col_nxt   = half16;
            end
            escp_pkg::CLS_PITCH216: phase_nxt = escp_pkg::PH_PITCH216;
            escp_pkg::CLS_PITCH72:  phase_nxt = escp_pkg::PH_PITCH72;
            escp_pkg::CLS_SP6:      pitch_nxt = 16'(drv.p6);
            escp_pkg::CLS_SP8:      pitch_nxt = 16'(drv.p8);
            escp_pkg::CLS_SP7:      pitch_nxt = 16'(drv.p7);
            escp_pkg::CLS_FEED_DN:  phase_nxt = escp_pkg::PH_FEED_DOWN;
            escp_pkg::CLS_FEED_UP:  phase_nxt = escp_pkg::PH_FEED_UP;
            escp_pkg::CLS_GFX60: begin
              dens_nxt  = escp_pkg::DENS_60;
              phase_nxt = escp_pkg::PH_BIT_LO;
            end
            escp_pkg::CLS_GFX120: begin
              dens_nxt  = escp_pkg::DENS_120;
              phase_nxt = escp_pkg::PH_BIT_LO;
            end
            escp_pkg::CLS_GFX240: begin
              dens_nxt  = escp_pkg::DENS_240;
              phase_nxt = escp_pkg::PH_BIT_LO;
            end
            escp_pkg::CLS_STAR: phase_nxt = escp_pkg::PH_STAR_MODE;
            default: ;
          endcase
        end
        escp_pkg::PH_PITCH216: begin
          pitch_nxt = f216_16;
          phase_nxt = escp_pkg::PH_TEXT;
        end
        escp_pkg::PH_PITCH72: begin
          pitch_nxt = 16'(q_head.p72);
          phase_nxt = escp_pkg::PH_TEXT;
        end
        escp_pkg::PH_FEED_DOWN: begin
          row_nxt   = sat16(22'(row_r) + 22'(f216_16));
          phase_nxt = escp_pkg::PH_TEXT;
        end
        escp_pkg::PH_FEED_UP: begin
          row_nxt   = (f216_16 > row_r) ? 16'd0 : row_r - f216_16;
          phase_nxt = escp_pkg::PH_TEXT;
        end
        escp_pkg::PH_BIT_LO: begin
          cnt_lo_nxt = b;
          phase_nxt  = escp_pkg::PH_BIT_HI;
        end
        escp_pkg::PH_STAR_LO: begin
          cnt_lo_nxt = b;
          phase_nxt  = escp_pkg::PH_STAR_HI;
        end
        escp_pkg::PH_STAR_MODE: begin
          sdens_nxt = q_head.star_dens;
          phase_nxt = escp_pkg::PH_STAR_LO;
        end
        escp_pkg::PH_BIT_HI, escp_pkg::PH_STAR_HI: begin
          exp_nxt  = exp_val;
          done_nxt = 16'd0;
          prod_nxt = 26'd0;
          if (phase_r == escp_pkg::PH_STAR_HI) dens_nxt = sdens_r;
          phase_nxt = (exp_val != 16'd0) ? escp_pkg::PH_DATA : escp_pkg::PH_TEXT;
        end
        escp_pkg::PH_DATA: begin
          flp_nxt  = 1'b0;
          done_nxt = done_inc;
          prod_nxt = prod_next_col;
          if (done_inc >= exp_r) begin
            col_nxt   = sat16(22'(col_r) + 22'(off_end));
            phase_nxt = escp_pkg::PH_TEXT;
          end
          emit    = 1'b1;
          ev_kind = escp_pkg::EV_COLUMN;
          ev_x    = sat16(22'(col_r) + 22'(off_cur));
          ev_y    = row_r;
          ev_g    = b;
          ev_w    = drv.step_w[dens_r];
          ev_h    = drv.vscale;
        end
        default: begin
          phase_nxt = escp_pkg::PH_TEXT;
          unique case (q_head.cls)
            escp_pkg::CLS_ESC: phase_nxt = escp_pkg::PH_ESC;
            escp_pkg::CLS_CR:  col_nxt   = half16;
            escp_pkg::CLS_LF: begin
              if (drv.skip && flp_r) begin
                flp_nxt = 1'b0;
              end else if ($signed({1'b0, row_lf}) >= drv.bottom) begin
                col_nxt = half16;
                row_nxt = 16'd0;
                emit    = 1'b1;
                ev_kind = escp_pkg::EV_PAGE_END;
              end else begin
                row_nxt = row_lf;
              end
            end
            escp_pkg::CLS_FF: begin
              flp_nxt = 1'b1;
              col_nxt = half16;
              row_nxt = 16'd0;
              emit    = 1'b1;
              ev_kind = escp_pkg::EV_PAGE_END;
            end
            default: begin
              if (q_head.printable) begin
                flp_nxt = 1'b0;
                col_nxt = sat16(22'(col_r) + 22'(drv.gadv));
                emit    = 1'b1;
                ev_kind = escp_pkg::EV_GLYPH;
                ev_x    = col_r;
                ev_y    = row_r;
                ev_g    = b;
                ev_w    = drv.gscale;
                ev_h    = drv.gscale;
              end
            end
          endcase
        end
      endcase
    end

    out_v_nxt = pop ? emit : (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= escp_pkg::PH_TEXT;
      flp_r    <= 1'b1;
      dens_r   <= escp_pkg::DENS_60;
      cnt_lo_r <= 8'd0;
      sdens_r  <= escp_pkg::DENS_60;
      exp_r    <= 16'd0;
      done_r   <= 16'd0;
      col_r    <= escp_pkg::HEAD_COL_RST;
      row_r    <= 16'd0;
      pitch_r  <= escp_pkg::PITCH_RST;
      out_v_r  <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      flp_r    <= flp_nxt;
      dens_r   <= dens_nxt;
      cnt_lo_r <= cnt_lo_nxt;
      sdens_r  <= sdens_nxt;
      exp_r    <= exp_nxt;
      done_r   <= done_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      pitch_r  <= pitch_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (pop && emit) begin
      out_event_kind    <= ev_kind;
      out_pos_x         <= ev_x;
      out_pos_y         <= ev_y;
      out_glyph_or_bits <= ev_g;
      out_dot_width     <= ev_w;
      out_dot_height    <= ev_h;
    end
  end

  assign out_valid = out_v_r;

endmodule

### design/escp_printer_command_parser.sv
// ----------------------------------------------------------------------------
// escp_printer_command_parser : ESC/P printer command parser
// Turns a printer byte stream into glyph, dot column and page end events.
//
//   channel  direction  handshake             payload
//   in       sink       in_valid / in_stall   in_data_byte
//   out      source     out_valid / out_stall event kind, position, bits, dots
//   cfg      sink       cfg_we                cfg_index, cfg_wdata
//
// One byte per cycle sustained while out_stall is low; a result passes the
// intake register, the queue and execution into the result register.
// A dots_per_inch write passes the derived-value register to reach the scale
// factors, and the product register after it to reach the column product.
// Reset is synchronous; no clearing pass.
// out_stall holds the result register and, once the two-entry queue fills,
// raises in_stall; there is no combinational path from out_stall to in_stall.
// ----------------------------------------------------------------------------
module escp_printer_command_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_event_kind,
  output logic [15:0] out_pos_x,
  output logic [15:0] out_pos_y,
  output logic [7:0]  out_glyph_or_bits,
  output logic [3:0]  out_dot_width,
  output logic [3:0]  out_dot_height,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  logic [9:0]             dpi;
  escp_pkg::cfg_derived_t drv;
  logic                   push, pop, q_full, q_valid;
  escp_pkg::q_entry_t     push_entry, q_head;

  escp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .dpi       (dpi),
    .drv       (drv)
  );

  escp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .dpi          (dpi),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  escp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (q_full),
    .not_empty  (q_valid),
    .head       (q_head)
  );

  escp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .drv               (drv),
    .q_valid           (q_valid),
    .q_head            (q_head),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_event_kind    (out_event_kind),
    .out_pos_x         (out_pos_x),
    .out_pos_y         (out_pos_y),
    .out_glyph_or_bits (out_glyph_or_bits),
    .out_dot_width     (out_dot_width),
    .out_dot_height    (out_dot_height)
  );

endmodule

### design/escp_checker.sv
// ----------------------------------------------------------------------------
// escp_checker : port checks for the command parser
// Watches the result channel and the event payload rules.
// ----------------------------------------------------------------------------
module escp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_event_kind,
  input logic [15:0] out_pos_x,
  input logic [15:0] out_pos_y,
  input logic [7:0]  out_glyph_or_bits,
  input logic [3:0]  out_dot_width,
  input logic [3:0]  out_dot_height
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_event_kind)
      && $stable(out_pos_x) && $stable(out_pos_y) && $stable(out_glyph_or_bits))
    else $error("stalled result changed");

  a_page_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == escp_pkg::EV_PAGE_END |-> out_pos_x == 16'd0
      && out_pos_y == 16'd0 && out_glyph_or_bits == 8'd0
      && out_dot_width == 4'd0 && out_dot_height == 4'd0)
    else $error("page end carries payload");

  a_column_dots: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == escp_pkg::EV_COLUMN |->
      out_dot_width != 4'd0 && out_dot_height != 4'd0)
    else $error("dot column of zero size");

  a_glyph: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_kind == escp_pkg::EV_GLYPH |->
      out_glyph_or_bits >= 8'd32 && out_glyph_or_bits <= 8'd126
      && out_dot_width == out_dot_height && out_dot_width != 4'd0)
    else $error("bad glyph event");

endmodule

bind escp_printer_command_parser escp_checker u_escp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_event_kind    (out_event_kind),
  .out_pos_x         (out_pos_x),
  .out_pos_y         (out_pos_y),
  .out_glyph_or_bits (out_glyph_or_bits),
  .out_dot_width     (out_dot_width),
  .out_dot_height    (out_dot_height)
);
